// ----- rtl/image_scale_ydown_xup_defines.svh -----
// Assertion macros for the image_scale_ydown_xup checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef IMAGE_SCALE_YDOWN_XUP_DEFINES_SVH
`define IMAGE_SCALE_YDOWN_XUP_DEFINES_SVH

// same-cycle implication
`define ISYX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isyx check failed");

// next-cycle implication
`define ISYX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("isyx check failed");

`endif

// ----- rtl/isyx_pkg.sv -----
// Shared types, codes and constants of the vertical downscale / horizontal upscale block.
// No dependencies.
`timescale 1ns / 1ps
package isyx_pkg;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_REPEAT_DEF = 64;
    localparam int CFG_W          = 19;
    localparam int CFG_IDX_W      = 3;
    localparam int NCH            = 5;
    localparam int SUM_W          = 24;
    localparam int RECIP_SHIFT    = 23;
    localparam int DVD_W          = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCL_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCL_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd5;

    localparam logic [2:0] MODE_MONO1 = 3'd0;
    localparam logic [2:0] MODE_MONO8 = 3'd1;
    localparam logic [2:0] MODE_RGB8  = 3'd2;
    localparam logic [2:0] MODE_XBGR8 = 3'd3;
    localparam logic [2:0] MODE_BGR8  = 3'd4;
    localparam logic [2:0] MODE_CMYK8 = 3'd5;

    typedef struct packed {
        logic [7:0] comp0;
        logic [7:0] comp1;
        logic [7:0] comp2;
        logic [7:0] comp3;
        logic [7:0] alpha_in;
    } t_in;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] alpha_out;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {DIV_Y, DIV_X, DIV_R} t_div_sel;

    typedef enum logic [2:0] {
        S_IDLE, S_DIVY, S_DIVX, S_DIVR, S_READ, S_ACC, S_MUL, S_EMIT
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     div_go;
        t_div_sel div_sel;
        logic     rd;
        logic     acc;
        logic     mul;
        logic     emit_adv;
    } t_cmd;

    typedef struct packed {
        logic dirty;
        logic grp_start;
        logic div_done;
        logic final_row;
        logic mul_last;
        logic emit_ok;
        logic out_last;
    } t_status;
endpackage

// ----- rtl/isyx_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module isyx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- rtl/isyx_datapath.sv -----
// Datapath: config registers, Bresenham terms, shared divider, line store, multiplier.
// Depends on isyx_pkg and isyx_ram.
`timescale 1ns / 1ps
module isyx_datapath #(
    parameter int MAX_WIDTH  = isyx_pkg::MAX_WIDTH_DEF,
    parameter int MAX_REPEAT = isyx_pkg::MAX_REPEAT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  isyx_pkg::t_cmd                 i_cmd,
    output isyx_pkg::t_status              o_status,
    input  isyx_pkg::t_in                  i_in_data,
    output isyx_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [isyx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [isyx_pkg::CFG_W-1:0]     i_cfg_wdata
);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW  = (WW > 16) ? WW : 16;
    localparam int RW  = $clog2(MAX_REPEAT + 1);
    localparam int NCH = isyx_pkg::NCH;
    localparam int SW  = isyx_pkg::SUM_W;
    localparam int QW  = isyx_pkg::DVD_W;
    localparam int SH  = isyx_pkg::RECIP_SHIFT;

    // config
    logic [12:0] r_src_w;
    logic [15:0] r_src_h;
    logic [18:0] r_scl_w;
    logic [15:0] r_scl_h;
    logic [2:0]  r_mode;
    logic        r_alpha_en;
    logic        r_dirty;

    // control state
    logic [15:0]   r_yp, r_yq, r_row_err, r_rows, r_grp;
    logic [18:0]   r_xp;
    logic [WW-1:0] r_xq, r_col, r_col_err;
    logic [QW-1:0] r_recip;
    logic [RW-1:0] r_step, r_rep;
    logic [2:0]    r_ch;

    // divider
    logic                 r_dbusy;
    logic [4:0]           r_dcnt;
    isyx_pkg::t_div_sel   r_dsel;
    logic [QW-1:0]        r_dvd, r_quo;
    logic [DW-1:0]        r_rem, r_dsr;

    // payload
    isyx_pkg::t_in  r_pix;
    logic [SW-1:0]  r_sum [NCH];
    logic [7:0]     r_avg [NCH];

    logic [WW-1:0]     w_eff, col_w, colerr_w;
    logic [15:0]       h_eff, grp_n;
    logic [16:0]       t_row, n_grp17;
    logic [DW:0]       d_shift, d_sub;
    logic              d_ge;
    logic [QW-1:0]     q_fin;
    logic [7:0]        pv [NCH];
    logic [NCH*SW-1:0] ram_rd, ram_wr;
    logic [SW-1:0]     new_sum [NCH];
    logic [WW:0]       t_col, col_inc;
    logic [19:0]       step20;
    logic [2*QW-1:0]   prod;
    logic              final_row;

    always_comb begin
        if (r_src_w == 13'd0) begin
            w_eff = WW'(1);
        end else if (32'(r_src_w) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_src_w);
        end
    end

    // row wraps to column 0 when the width has shrunk under it
    assign col_w    = (r_col >= w_eff) ? '0 : r_col;
    assign colerr_w = (r_col >= w_eff) ? '0 : r_col_err;
    assign h_eff    = (r_scl_h == 16'd0) ? 16'd1 : r_scl_h;

    always_comb begin
        t_row = {1'b0, r_row_err} + {1'b0, r_yq};
        if (t_row >= {1'b0, h_eff}) begin
            t_row   = t_row - {1'b0, h_eff};
            n_grp17 = {1'b0, r_yp} + 17'd1;
        end else begin
            n_grp17 = {1'b0, r_yp};
        end
        grp_n = (n_grp17[15:0] == 16'd0) ? 16'd1 : n_grp17[15:0];
    end

    // restoring divide step
    assign d_shift = {r_rem, r_dvd[QW-1]};
    assign d_ge    = d_shift >= {1'b0, r_dsr};
    assign d_sub   = d_ge ? (d_shift - {1'b0, r_dsr}) : d_shift;
    assign q_fin   = {r_quo[QW-2:0], d_ge};

    assign pv[0] = r_pix.comp0;
    assign pv[1] = r_pix.comp1;
    assign pv[2] = r_pix.comp2;
    assign pv[3] = r_pix.comp3;
    assign pv[4] = r_pix.alpha_in;

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            new_sum[i] = (r_rows == 16'd0) ? SW'(pv[i])
                                           : ram_rd[i*SW +: SW] + SW'(pv[i]);
            ram_wr[i*SW +: SW] = new_sum[i];
        end
    end

    assign final_row = ({1'b0, r_rows} + 17'd1) >= {1'b0, r_grp};

    always_comb begin
        t_col = {1'b0, r_col_err} + {1'b0, r_xq};
        if (t_col >= {1'b0, w_eff}) begin
            t_col  = t_col - {1'b0, w_eff};
            step20 = {1'b0, r_xp} + 20'd1;
        end else begin
            step20 = {1'b0, r_xp};
        end
        col_inc = {1'b0, r_col} + (WW+1)'(1);
    end

    assign prod = {{(QW-SW){1'b0}}, r_sum[r_ch]} * r_recip;

    isyx_ram #(.WIDTH(NCH*SW), .DEPTH(MAX_WIDTH), .AW(AW)) u_line (
        .i_clk  (i_clk),
        .i_we   (i_cmd.acc),
        .i_waddr(r_col[AW-1:0]),
        .i_wdata(ram_wr),
        .i_re   (i_cmd.rd),
        .i_raddr(r_col[AW-1:0]),
        .o_rdata(ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= 13'd1;
            r_src_h    <= 16'd1;
            r_scl_w    <= 19'd1;
            r_scl_h    <= 16'd1;
            r_mode     <= isyx_pkg::MODE_MONO8;
            r_alpha_en <= 1'b0;
            r_dirty    <= 1'b1;
            r_yp       <= '0;
            r_yq       <= '0;
            r_xp       <= '0;
            r_xq       <= '0;
            r_row_err  <= '0;
            r_rows     <= '0;
            r_grp      <= '0;
            r_recip    <= '0;
            r_col      <= '0;
            r_col_err  <= '0;
            r_step     <= '0;
            r_rep      <= '0;
            r_ch       <= '0;
            r_dbusy    <= 1'b0;
            r_dcnt     <= '0;
            r_dsel     <= isyx_pkg::DIV_Y;
        end else begin
            if (i_cmd.div_go && i_cmd.div_sel == isyx_pkg::DIV_Y) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                unique case (i_cfg_idx)
                    isyx_pkg::CFG_SRC_W: r_src_w    <= i_cfg_wdata[12:0];
                    isyx_pkg::CFG_SRC_H: r_src_h    <= i_cfg_wdata[15:0];
                    isyx_pkg::CFG_SCL_W: r_scl_w    <= i_cfg_wdata[18:0];
                    isyx_pkg::CFG_SCL_H: r_scl_h    <= i_cfg_wdata[15:0];
                    isyx_pkg::CFG_MODE:  r_mode     <= i_cfg_wdata[2:0];
                    isyx_pkg::CFG_ALPHA: r_alpha_en <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // divider
            if (r_dbusy) begin
                r_rem  <= d_sub[DW-1:0];
                r_quo  <= q_fin;
                r_dvd  <= {r_dvd[QW-2:0], 1'b0};
                r_dcnt <= r_dcnt + 5'd1;
                if (r_dcnt == 5'(QW - 1)) begin
                    r_dbusy <= 1'b0;
                    unique case (r_dsel)
                        isyx_pkg::DIV_Y: begin
                            r_yp <= q_fin[15:0];
                            r_yq <= d_sub[15:0];
                        end
                        isyx_pkg::DIV_X: begin
                            r_xp <= q_fin[18:0];
                            r_xq <= d_sub[WW-1:0];
                        end
                        default: r_recip <= q_fin;
                    endcase
                end
            end
            if (i_cmd.div_go) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
                r_dsel  <= i_cmd.div_sel;
                r_rem   <= '0;
                r_quo   <= '0;
                unique case (i_cmd.div_sel)
                    isyx_pkg::DIV_Y: begin
                        r_dvd <= QW'(r_src_h);
                        r_dsr <= DW'(h_eff);
                    end
                    isyx_pkg::DIV_X: begin
                        r_dvd <= QW'(r_scl_w);
                        r_dsr <= DW'(w_eff);
                    end
                    default: begin
                        r_dvd <= QW'(1) << SH;
                        r_dsr <= DW'(grp_n);
                    end
                endcase
            end

            if (i_cmd.accept) begin
                r_col     <= col_w;
                r_col_err <= colerr_w;
                if (r_rows == 16'd0 && col_w == '0) begin
                    r_row_err <= t_row[15:0];
                    r_grp     <= grp_n;
                end
            end

            if (i_cmd.acc) begin
                r_rep <= '0;
                r_ch  <= '0;
                if (final_row) begin
                    r_col_err <= t_col[WW-1:0];
                    r_step    <= (32'(step20) > 32'(MAX_REPEAT)) ? RW'(MAX_REPEAT)
                                                                 : RW'(step20);
                end
                if (col_inc >= {1'b0, w_eff}) begin
                    r_col     <= '0;
                    r_col_err <= '0;
                    r_rows    <= final_row ? 16'd0 : r_rows + 16'd1;
                end else begin
                    r_col <= col_inc[WW-1:0];
                end
            end

            if (i_cmd.mul) begin
                r_ch <= r_ch + 3'd1;
            end
            if (i_cmd.emit_adv) begin
                r_rep <= r_rep + RW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_in_data;
        end
        if (i_cmd.acc) begin
            for (int i = 0; i < NCH; i++) begin
                r_sum[i] <= new_sum[i];
            end
        end
        if (i_cmd.mul) begin
            r_avg[r_ch] <= prod[SH +: 8];
        end
    end

    always_comb begin
        o_out_data = '0;
        unique case (r_mode)
            isyx_pkg::MODE_MONO8: o_out_data.byte0 = r_avg[0];
            isyx_pkg::MODE_RGB8: begin
                o_out_data.byte0 = r_avg[0];
                o_out_data.byte1 = r_avg[1];
                o_out_data.byte2 = r_avg[2];
            end
            isyx_pkg::MODE_XBGR8: begin
                o_out_data.byte0 = r_avg[2];
                o_out_data.byte1 = r_avg[1];
                o_out_data.byte2 = r_avg[0];
                o_out_data.byte3 = 8'd255;
            end
            isyx_pkg::MODE_BGR8: begin
                o_out_data.byte0 = r_avg[2];
                o_out_data.byte1 = r_avg[1];
                o_out_data.byte2 = r_avg[0];
            end
            isyx_pkg::MODE_CMYK8: begin
                o_out_data.byte0 = r_avg[0];
                o_out_data.byte1 = r_avg[1];
                o_out_data.byte2 = r_avg[2];
                o_out_data.byte3 = r_avg[3];
            end
            default: ;
        endcase
        o_out_data.alpha_out = r_alpha_en ? r_avg[4] : 8'd0;
        o_out_data.last      = ({1'b0, r_rep} + (RW+1)'(1)) == {1'b0, r_step};
    end

    assign o_status.dirty     = r_dirty;
    assign o_status.grp_start = (r_rows == 16'd0) && (col_w == '0);
    assign o_status.div_done  = r_dbusy && (r_dcnt == 5'(QW - 1));
    assign o_status.final_row = final_row;
    assign o_status.mul_last  = r_ch == 3'(NCH - 1);
    assign o_status.emit_ok   = (r_mode >= isyx_pkg::MODE_MONO8) &&
                                (r_mode <= isyx_pkg::MODE_CMYK8) && (r_step != '0);
    assign o_status.out_last  = o_out_data.last;
endmodule

// ----- rtl/isyx_ctrl.sv -----
// Controller state machine: sequences divide, line store access, multiply and emit.
// Depends on isyx_pkg.
`timescale 1ns / 1ps
module isyx_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  isyx_pkg::t_status i_status,
    output isyx_pkg::t_cmd    o_cmd
);
    isyx_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isyx_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = !(r_state == isyx_pkg::S_IDLE && !i_status.dirty);
        o_out_valid = r_state == isyx_pkg::S_EMIT;
        unique case (r_state)
            isyx_pkg::S_IDLE: begin
                if (i_status.dirty) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = isyx_pkg::DIV_Y;
                    n_state       = isyx_pkg::S_DIVY;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.grp_start) begin
                        o_cmd.div_go  = 1'b1;
                        o_cmd.div_sel = isyx_pkg::DIV_R;
                        n_state       = isyx_pkg::S_DIVR;
                    end else begin
                        n_state = isyx_pkg::S_READ;
                    end
                end
            end
            isyx_pkg::S_DIVY: begin
                if (i_status.div_done) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = isyx_pkg::DIV_X;
                    n_state       = isyx_pkg::S_DIVX;
                end
            end
            isyx_pkg::S_DIVX: begin
                if (i_status.div_done) n_state = isyx_pkg::S_IDLE;
            end
            isyx_pkg::S_DIVR: begin
                if (i_status.div_done) n_state = isyx_pkg::S_READ;
            end
            isyx_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = isyx_pkg::S_ACC;
            end
            isyx_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.final_row ? isyx_pkg::S_MUL : isyx_pkg::S_IDLE;
            end
            isyx_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_status.mul_last) begin
                    n_state = i_status.emit_ok ? isyx_pkg::S_EMIT : isyx_pkg::S_IDLE;
                end
            end
            isyx_pkg::S_EMIT: begin
                if (!i_out_stall) begin
                    o_cmd.emit_adv = 1'b1;
                    if (i_status.out_last) n_state = isyx_pkg::S_IDLE;
                end
            end
            default: n_state = isyx_pkg::S_IDLE;
        endcase
    end
endmodule

// ----- rtl/image_scale_ydown_xup.sv -----
// Each source pixel passes accept, line store read and sum write back in turn; a group's
// first pixel adds the reciprocal divide, and a group's last row adds a multiply per
// channel plus the emission of each copy. A config write brings on the height and width
// divides, which run before the next request is taken.
// Reset (synchronous, active low) loads register defaults; the line store is not cleared.
`timescale 1ns / 1ps
module image_scale_ydown_xup #(
    parameter int MAX_WIDTH  = isyx_pkg::MAX_WIDTH_DEF,
    parameter int MAX_REPEAT = isyx_pkg::MAX_REPEAT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // source pixel requests
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  isyx_pkg::t_in                  i_in_data,
    // scaled pixel requests
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output isyx_pkg::t_out                 o_out_data,
    // register writes
    input  logic                           i_cfg_we,
    input  logic [isyx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [isyx_pkg::CFG_W-1:0]     i_cfg_wdata
);
    // Controller owns sequencing; the datapath owns every value. The shared
    // 24-step divider serves the row split (height), the column split (width)
    // after a config change, and the group reciprocal at each group start.
    isyx_pkg::t_cmd    cmd;
    isyx_pkg::t_status status;

    isyx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    isyx_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_REPEAT(MAX_REPEAT)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );
endmodule

// ----- rtl/isyx_checker.sv -----
// Port-level checks for image_scale_ydown_xup, bound to the top level.
// Depends on isyx_pkg and image_scale_ydown_xup_defines.svh.
`timescale 1ns / 1ps
`include "image_scale_ydown_xup_defines.svh"
module isyx_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input isyx_pkg::t_out o_out_data
);
    // no new source pixel while copies are going out
    `ISYX_ASSERT_NOW(a_emit_blocks_in, o_out_valid, o_in_stall)
    // an accepted pixel keeps the input closed for at least the next cycle
    `ISYX_ASSERT_NEXT(a_accept_stalls, i_in_valid && !o_in_stall, o_in_stall)
    // a stalled result holds
    `ISYX_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_out_data))
endmodule

bind image_scale_ydown_xup isyx_checker u_isyx_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench of image_scale_ydown_xup: directed table, then random images.
// Depends on rtl/isyx_pkg.sv and rtl/image_scale_ydown_xup.sv.
`timescale 1ns / 1ps
module tb_top;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  SETTLE      = 120;      // covers divide after writes plus pipe latency
    localparam int  LSTORE      = 4096;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    isyx_pkg::t_in  i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    isyx_pkg::t_out o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [isyx_pkg::CFG_IDX_W-1:0] i_cfg_idx = isyx_pkg::CFG_SRC_W;
    logic [isyx_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    always #6 i_clk = ~i_clk;

    image_scale_ydown_xup i_dut (.*);

    // ---------------------------------------------------------------
    // Predictor: mirror of registers, line store and both error terms
    // ---------------------------------------------------------------
    logic [12:0] src_w;
    logic [15:0] src_h;
    logic [18:0] scl_w;
    logic [15:0] scl_h;
    logic [2:0]  mode;
    logic        alpha_en;

    logic [23:0] col_sum [isyx_pkg::NCH][LSTORE];
    logic [15:0] row_err, row_cnt, grp_rows;
    logic [23:0] recip;
    int unsigned col_idx, col_err;

    isyx_pkg::t_out scaled_q [$];     // expected scaled pixels, oldest first
    int   n_err = 0;
    int   n_in = 0;
    int   n_out = 0;
    int   cycles = 0;

    function automatic int unsigned line_width();
        int unsigned w;
        w = src_w;
        if (w == 0) w = 1;
        if (w > LSTORE) w = LSTORE;
        return w;
    endfunction

    function automatic void open_group();
        int unsigned h, yp, yq, t, n;
        h = (scl_h != 0) ? scl_h : 1;
        yp = src_h / h;
        yq = src_h % h;
        t = row_err + yq;
        if (t >= h) begin
            t -= h;
            n = yp + 1;
        end else begin
            n = yp;
        end
        if (n == 0) n = 1;
        row_err = t[15:0];
        grp_rows = n[15:0];
        if (grp_rows == 0) grp_rows = 1;
        recip = 24'((1 << 23) / grp_rows);
    endfunction

    // accumulate one source pixel; push the scaled copies unless the caller
    // supplies its own typed expectation
    function automatic void predict_pixel(input isyx_pkg::t_in px, input bit typed);
        int unsigned w, c, xp, xq, t, reps;
        logic [7:0]  v [isyx_pkg::NCH];
        logic [7:0]  avg [isyx_pkg::NCH];
        logic [47:0] prod;
        isyx_pkg::t_out o;
        w = line_width();
        v = '{px.comp0, px.comp1, px.comp2, px.comp3, px.alpha_in};
        if (col_idx >= w) begin
            col_idx = 0;
            col_err = 0;
        end
        if (row_cnt == 0 && col_idx == 0) open_group();
        c = col_idx;
        for (int ch = 0; ch < isyx_pkg::NCH; ch++) begin
            if (row_cnt == 0) col_sum[ch][c] = {16'd0, v[ch]};
            else col_sum[ch][c] = col_sum[ch][c] + v[ch];
        end
        if (row_cnt + 1 >= grp_rows) begin
            xp = scl_w / w;
            xq = scl_w % w;
            t = col_err + xq;
            if (t >= w) begin
                t -= w;
                reps = xp + 1;
            end else begin
                reps = xp;
            end
            col_err = t & 16'hFFFF;
            if (reps > isyx_pkg::MAX_REPEAT_DEF) reps = isyx_pkg::MAX_REPEAT_DEF;
            for (int ch = 0; ch < isyx_pkg::NCH; ch++) begin
                prod = col_sum[ch][c] * recip;
                avg[ch] = prod[30:23];
            end
            o = '0;
            case (mode)
                isyx_pkg::MODE_MONO8: o.byte0 = avg[0];
                isyx_pkg::MODE_RGB8: begin
                    o.byte0 = avg[0]; o.byte1 = avg[1]; o.byte2 = avg[2];
                end
                isyx_pkg::MODE_XBGR8: begin
                    o.byte0 = avg[2]; o.byte1 = avg[1]; o.byte2 = avg[0]; o.byte3 = 8'hFF;
                end
                isyx_pkg::MODE_BGR8: begin
                    o.byte0 = avg[2]; o.byte1 = avg[1]; o.byte2 = avg[0];
                end
                isyx_pkg::MODE_CMYK8: begin
                    o.byte0 = avg[0]; o.byte1 = avg[1]; o.byte2 = avg[2]; o.byte3 = avg[3];
                end
                default: reps = 0;  // mono1 and undefined codes emit nothing
            endcase
            o.alpha_out = alpha_en ? avg[4] : 8'd0;
            if (!typed) begin
                for (int i = 0; i < reps; i++) begin
                    o.last = (i + 1 == reps);
                    scaled_q.push_back(o);
                end
            end
        end
        col_idx++;
        if (col_idx >= w) begin
            col_idx = 0;
            col_err = 0;
            row_cnt++;
            if (row_cnt >= grp_rows) row_cnt = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Register writes, only while idle
    // ---------------------------------------------------------------
    task automatic write_regs(input int sw, input int sh, input int scw, input int sch,
                              input int md, input int al);
        int unsigned vals [6];
        logic [isyx_pkg::CFG_IDX_W-1:0] idx [6];
        vals = '{sw, sh, scw, sch, md, al};
        idx  = '{isyx_pkg::CFG_SRC_W, isyx_pkg::CFG_SRC_H, isyx_pkg::CFG_SCL_W,
                 isyx_pkg::CFG_SCL_H, isyx_pkg::CFG_MODE, isyx_pkg::CFG_ALPHA};
        wait (scaled_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);   // mono1 pixels leave nothing to wait on
        for (int i = 0; i < 6; i++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[i];
            i_cfg_wdata <= isyx_pkg::CFG_W'(vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        src_w = 13'(sw); src_h = 16'(sh); scl_w = 19'(scw); scl_h = 16'(sch);
        mode = 3'(md); alpha_en = al[0];
    endtask

    // ---------------------------------------------------------------
    // Source side: gaps, then one request held until taken
    // ---------------------------------------------------------------
    bit quiet_src = 0;

    function automatic int gap_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid drops after each request before the next one is raised; the block
    // stalls in the cycle after an accept anyway
    task automatic send_pixel(input isyx_pkg::t_in px, input bit typed);
        repeat (1 + gap_len(quiet_src)) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        predict_pixel(px, typed);
        n_in++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic isyx_pkg::t_in rand_pixel();
        isyx_pkg::t_in p;
        p = '{pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        return p;
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stall, check at the rising edge
    // ---------------------------------------------------------------
    int  hold_left = 0;
    bit  quiet_dst = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet_dst && $urandom_range(0, 9) < 3) begin
            hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : 0;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        isyx_pkg::t_out want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d scaled pixels still owed", $time, scaled_q.size());
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_out++;
            if (scaled_q.size() == 0) begin
                n_err++;
                $display("%0t unexpected scaled pixel: expected none, actual %h",
                         $time, o_out_data);
            end else begin
                want = scaled_q.pop_front();
                if (o_out_data.byte0 != want.byte0 || o_out_data.byte1 != want.byte1 ||
                    o_out_data.byte2 != want.byte2 || o_out_data.byte3 != want.byte3 ||
                    o_out_data.alpha_out != want.alpha_out ||
                    o_out_data.last != want.last) begin
                    n_err++;
                    $display("%0t mismatch: expected b=%h %h %h %h a=%h last=%b",
                             $time, want.byte0, want.byte1, want.byte2, want.byte3,
                             want.alpha_out, want.last);
                    $display("%0t           actual   b=%h %h %h %h a=%h last=%b",
                             $time, o_out_data.byte0, o_out_data.byte1, o_out_data.byte2,
                             o_out_data.byte3, o_out_data.alpha_out, o_out_data.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed table: config (optional), pixel, repeat, typed expectation
    // ---------------------------------------------------------------
    typedef struct {
        bit   cfg;
        int   sw, sh, scw, sch, md, al;
        isyx_pkg::t_in  px;
        int   reps;
        bit   typed;
        isyx_pkg::t_out want;
    } t_row;

    t_row plan [$];

    function automatic void add_row(input bit cfg, input int sw, input int sh, input int scw,
                                    input int sch, input int md, input int al,
                                    input isyx_pkg::t_in px, input int reps, input bit typed,
                                    input isyx_pkg::t_out want);
        t_row r;
        r = '{cfg, sw, sh, scw, sch, md, al, px, reps, typed, want};
        plan.push_back(r);
    endfunction

    initial begin
        t_row r;
        int   target, sent, sw, sh, scw, sch, md;

        src_w = 1; src_h = 1; scl_w = 1; scl_h = 1; mode = isyx_pkg::MODE_MONO8;
        alpha_en = 0;
        row_err = 0; row_cnt = 0; grp_rows = 0; recip = 0; col_idx = 0; col_err = 0;

        // one-row, one-column images pass the pixel straight through
        add_row(0, 1, 1, 1, 1, isyx_pkg::MODE_MONO8, 0, '{8'h5A, 8'h11, 8'h22, 8'h33, 8'h44},
                1, 1, '{8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
        add_row(1, 1, 1, 1, 1, isyx_pkg::MODE_RGB8, 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
                1, 1, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1});
        add_row(1, 1, 1, 1, 1, isyx_pkg::MODE_XBGR8, 0, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05},
                1, 1, '{8'h03, 8'h02, 8'h01, 8'hFF, 8'h00, 1'b1});
        add_row(1, 1, 1, 1, 1, isyx_pkg::MODE_BGR8, 0, '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05},
                1, 1, '{8'h03, 8'h02, 8'h01, 8'h00, 8'h00, 1'b1});
        add_row(1, 1, 1, 1, 1, isyx_pkg::MODE_CMYK8, 1, '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50},
                1, 1, '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 1'b1});
        add_row(1, 1, 1, 1, 1, isyx_pkg::MODE_CMYK8, 0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                1, 1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
        // mono1 and undefined codes: summed, nothing emitted
        add_row(1, 1, 1, 3, 1, isyx_pkg::MODE_MONO1, 1, '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA},
                1, 0, '0);
        add_row(1, 1, 1, 3, 1, 6, 1, '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1, 0, '0);
        add_row(1, 1, 1, 3, 1, 7, 1, '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1, 0, '0);
        // replication, saturation at the widest scaled width, zero repeat
        add_row(1, 1, 1, 3, 1, isyx_pkg::MODE_RGB8, 1, '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A},
                1, 0, '0);
        add_row(1, 1, 1, 19'h7FFFF, 1, isyx_pkg::MODE_XBGR8, 1,
                '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h81}, 1, 0, '0);
        add_row(1, 1, 1, 0, 1, isyx_pkg::MODE_RGB8, 0, '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h81},
                1, 0, '0);
        // zero width / zero scaled height taken as one; tallest sizes
        add_row(1, 0, 1, 2, 0, isyx_pkg::MODE_MONO8, 0, '{8'hC3, 8'h3C, 8'h00, 8'h00, 8'h00},
                1, 0, '0);
        add_row(1, 1, 16'hFFFF, 1, 16'hFFFF, isyx_pkg::MODE_CMYK8, 1,
                '{8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h99}, 1, 0, '0);
        // scaled height above source height: empty group becomes one row
        add_row(1, 1, 1, 1, 16'hFFFF, isyx_pkg::MODE_BGR8, 1,
                '{8'h21, 8'h43, 8'h65, 8'h87, 8'hA9}, 2, 0, '0);
        // two-row groups averaged, then width shrinks mid-row so the row wraps
        add_row(1, 2, 4, 5, 2, isyx_pkg::MODE_RGB8, 1, '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE},
                4, 0, '0);
        add_row(1, 4, 2, 4, 1, isyx_pkg::MODE_MONO8, 0, '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50},
                3, 0, '0);
        add_row(1, 2, 2, 4, 1, isyx_pkg::MODE_MONO8, 1, '{8'hEE, 8'hDD, 8'hCC, 8'hBB, 8'hAA},
                4, 0, '0);
        // widest row value saturates to the line store depth: two copies per column
        add_row(1, 13'h1FFF, 1, 2 * LSTORE, 1, isyx_pkg::MODE_MONO8, 0,
                '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05}, 4, 0, '0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            r = plan[k];
            if (r.cfg) write_regs(r.sw, r.sh, r.scw, r.sch, r.md, r.al);
            quiet_src = (r.reps > 8);
            for (int i = 0; i < r.reps; i++) send_pixel(r.px, r.typed);
            if (r.typed) scaled_q.push_back(r.want);
        end

        // random images; each phase closes on a group boundary so that a
        // wider row never reads line store columns left from another width
        for (int ph = 0; ph < 8; ph++) begin
            sw  = $urandom_range(1, 6);
            sh  = $urandom_range(1, 7);
            sch = ($urandom_range(0, 5) == 0) ? $urandom_range(sh, sh + 3)
                                               : $urandom_range(1, sh);
            scw = ($urandom_range(0, 7) == 0) ? sw * 70
                                               : sw * $urandom_range(1, 4) +
                                                 $urandom_range(0, sw - 1);
            md  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                               : $urandom_range(isyx_pkg::MODE_MONO8,
                                                                isyx_pkg::MODE_CMYK8);
            write_regs(sw, sh, scw, sch, md, $urandom_range(0, 1));
            quiet_src = (ph % 3 == 2);
            quiet_dst = (ph % 4 == 3);
            target = 8;
            sent = 0;
            while (sent < target || row_cnt != 0 || col_idx != 0) begin
                send_pixel(rand_pixel(), 0);
                sent++;
                if (ph == 4 && sent == 6) wait (scaled_q.size() == 0);
            end
        end
        quiet_dst = 0;

        fork
            wait (scaled_q.size() == 0);
        join
        repeat (SETTLE) @(posedge i_clk);

        $display("tb: %0d source pixels, %0d scaled pixels over all color modes,", n_in, n_out);
        $display("tb: replication, saturation, wrap and averaging groups; %0d errors", n_err);
        if (n_err == 0 && scaled_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
